[hdl/rau_pkg.sv]
// ----------------------------------------------------------------------------
// Rational arithmetic unit package
// Shared widths and constants for the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

  // Result range: numerator signed NUM_WIDTH bits, denominator below LIMIT
  localparam int NUM_WIDTH = 64;
  localparam logic [63:0] LIMIT = 64'd1 << (NUM_WIDTH - 1);

  // Operand and double-width intermediate widths
  localparam int OW = 64;
  localparam int DW = 2 * OW;

  // Command codes
  localparam logic [3:0] CMD_NORM = 4'd0;
  localparam logic [3:0] CMD_ADD  = 4'd1;
  localparam logic [3:0] CMD_SUB  = 4'd2;
  localparam logic [3:0] CMD_MUL  = 4'd3;
  localparam logic [3:0] CMD_DIV  = 4'd4;
  localparam logic [3:0] CMD_NEG  = 4'd5;
  localparam logic [3:0] CMD_EQ   = 4'd6;
  localparam logic [3:0] CMD_LT   = 4'd7;
  localparam logic [3:0] CMD_REB  = 4'd8;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_OVF   = 2'd1;
  localparam logic [1:0] ST_ZDEN  = 2'd2;
  localparam logic [1:0] ST_INEX  = 2'd3;

endpackage

[hdl/rational_arithmetic_unit_top.sv]
// ----------------------------------------------------------------------------
// Rational arithmetic unit
// Exact fraction arithmetic, compare and rebase with gcd reduction.
// ----------------------------------------------------------------------------
// Error and unknown commands go straight to the output; compares use the
// three products only; reduced results run a binary gcd loop (one shift,
// swap or subtract per cycle) and then two divisions.
// Throughput: one word at a time; in_stall stays high until the result is
// placed in the output register. rst_n clears control state only.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_top import rau_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [3:0]         in_cmd,
  input  logic signed [63:0] in_left_num,
  input  logic signed [63:0] in_left_den,
  input  logic signed [63:0] in_right_num,
  input  logic [62:0]        in_right_den,
  input  logic [62:0]        in_new_den,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [63:0] out_res_num,
  output logic [62:0]        out_res_den,
  output logic               out_compare_true,
  output logic [1:0]         out_status
);

  typedef enum logic [3:0] {
    S_IDLE, S_CHK, S_MUL, S_CMB, S_RB, S_GZ, S_G2, S_GA, S_GB, S_GS, S_GK,
    S_DN, S_DD, S_FIN, S_PUT
  } state_t;

  state_t        state_r;
  logic          go_r;
  logic [1:0]    mi_r;

  // captured operands as sign and magnitude
  logic [3:0]    cmd_r;
  logic          lneg_r, rneg_r, xneg_r, yneg_r;
  logic [OW-1:0] lnm_r, ldm_r, rnm_r;
  logic [62:0]   rdm_r, nd_r;

  // products, working fraction and gcd registers
  logic [DW-1:0] px_r, py_r, pd_r;
  logic          nneg_r;
  logic [DW-1:0] nm_r, dd_r;
  logic [DW-1:0] ga_r, gb_r;
  logic [6:0]    gk_r;

  // pending result
  logic [63:0]   on_num_r;
  logic [62:0]   on_den_r;
  logic          on_cmp_r;
  logic [1:0]    on_st_r;

  // output register
  logic          out_valid_r;
  logic [63:0]   out_num_r;
  logic [62:0]   out_den_r;
  logic          out_cmp_r;
  logic [1:0]    out_st_r;

  // input capture helpers
  logic [63:0]   lnum_u, lden_u, rnum_u;
  logic [63:0]   lnm_w, ldm_w, rnm_w;
  logic          lneg_w, rneg_w;

  assign lnum_u = in_left_num;
  assign lden_u = in_left_den;
  assign rnum_u = in_right_num;
  assign lnm_w  = lnum_u[63] ? (~lnum_u + 64'd1) : lnum_u;
  assign ldm_w  = lden_u[63] ? (~lden_u + 64'd1) : lden_u;
  assign rnm_w  = rnum_u[63] ? (~rnum_u + 64'd1) : rnum_u;
  assign lneg_w = (lnum_u[63] ^ lden_u[63]) && (lnm_w != 64'd0);
  assign rneg_w = rnum_u[63] && (rnm_w != 64'd0);

  // shared 129-bit add / subtract / compare
  logic [DW-1:0] alu_a, alu_b;
  logic          alu_sub;
  logic [DW:0]   alu_res;
  logic          alu_borrow, alu_zero;

  assign alu_a   = (state_r == S_GS) ? gb_r : px_r;
  assign alu_b   = (state_r == S_GS) ? ga_r : py_r;
  assign alu_sub = (state_r == S_GS) || (xneg_r != yneg_r) ||
                   (cmd_r == CMD_EQ) || (cmd_r == CMD_LT);
  assign alu_res = alu_sub ? ({1'b0, alu_a} - {1'b0, alu_b})
                           : ({1'b0, alu_a} + {1'b0, alu_b});
  assign alu_borrow = alu_sub && alu_res[DW];
  assign alu_zero   = (alu_res[DW-1:0] == '0);

  // multiplier operand selection per job
  logic          mul_start, mul_done;
  logic [OW-1:0] mul_a, mul_b;
  logic [DW-1:0] mul_prod;

  always_comb begin
    unique case (mi_r)
      2'd0: begin
        mul_a = lnm_r;
        if (cmd_r == CMD_MUL)      mul_b = rnm_r;
        else if (cmd_r == CMD_REB) mul_b = {1'b0, nd_r};
        else                       mul_b = {1'b0, rdm_r};
      end
      2'd1: begin
        mul_a = rnm_r;
        mul_b = ldm_r;
      end
      default: begin
        mul_a = ldm_r;
        mul_b = (cmd_r == CMD_DIV) ? rnm_r : {1'b0, rdm_r};
      end
    endcase
  end

  assign mul_start = (state_r == S_MUL) && !go_r;

  rau_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  // divider operand selection
  logic          div_start, div_done;
  logic [DW-1:0] div_num, div_den, div_quo, div_rem;

  assign div_start = ((state_r == S_RB) || (state_r == S_DN) || (state_r == S_DD)) && !go_r;
  assign div_num   = (state_r == S_RB) ? px_r : (state_r == S_DN) ? nm_r : dd_r;
  assign div_den   = (state_r == S_RB) ? {{(DW-OW){1'b0}}, ldm_r} : ga_r;

  rau_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  // range check of the finished fraction
  logic num_fit, den_fit;

  assign num_fit = (nm_r[DW-1:OW] == '0) &&
                   ((nm_r[OW-1:0] < LIMIT) || (nneg_r && (nm_r[OW-1:0] == LIMIT)));
  assign den_fit = (dd_r[DW-1:OW] == '0) && (dd_r[OW-1:0] < LIMIT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      go_r        <= 1'b0;
      mi_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // drop the output word once taken, unless a new word replaces it
      if (out_valid_r && !out_stall && (state_r != S_PUT)) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            cmd_r   <= in_cmd;
            lnm_r   <= lnm_w;
            ldm_r   <= ldm_w;
            rnm_r   <= rnm_w;
            lneg_r  <= lneg_w;
            rneg_r  <= rneg_w;
            rdm_r   <= in_right_den;
            nd_r    <= in_new_den;
            xneg_r  <= lneg_w;
            yneg_r  <= (in_cmd == CMD_SUB) ? ((rnm_w != 64'd0) && !rneg_w) : rneg_w;
            state_r <= S_CHK;
          end
        end

        S_CHK: begin
          on_num_r <= '0;
          on_den_r <= '0;
          on_cmp_r <= 1'b0;
          priority if (cmd_r > CMD_REB) begin
            on_st_r <= ST_OK;
            state_r <= S_PUT;
          end else if (ldm_r == 64'd0) begin
            on_st_r <= ST_ZDEN;
            state_r <= S_PUT;
          end else if (cmd_r == CMD_NORM || cmd_r == CMD_NEG) begin
            on_st_r <= ST_OK;
            nm_r    <= {{(DW-OW){1'b0}}, lnm_r};
            dd_r    <= {{(DW-OW){1'b0}}, ldm_r};
            nneg_r  <= (cmd_r == CMD_NORM) ? lneg_r : (!lneg_r && lnm_r != 64'd0);
            state_r <= S_GZ;
          end else if (cmd_r == CMD_REB) begin
            if (nd_r == 63'd0) begin
              on_st_r <= ST_ZDEN;
              state_r <= S_PUT;
            end else begin
              on_st_r <= ST_OK;
              mi_r    <= '0;
              state_r <= S_MUL;
            end
          end else if (rdm_r == 63'd0 || (cmd_r == CMD_DIV && rnm_r == 64'd0)) begin
            on_st_r <= ST_ZDEN;
            state_r <= S_PUT;
          end else begin
            on_st_r <= ST_OK;
            mi_r    <= '0;
            state_r <= S_MUL;
          end
        end

        S_MUL: begin
          // run the three products in turn
          if (!go_r) begin
            go_r <= 1'b1;
          end else if (mul_done) begin
            go_r <= 1'b0;
            unique case (mi_r)
              2'd0:    px_r <= mul_prod;
              2'd1:    py_r <= mul_prod;
              default: pd_r <= mul_prod;
            endcase
            if (mi_r == 2'd2) begin
              state_r <= (cmd_r == CMD_REB) ? S_RB : S_CMB;
            end else begin
              mi_r <= mi_r + 2'd1;
            end
          end
        end

        S_CMB: begin
          dd_r <= pd_r;
          unique case (cmd_r)
            CMD_ADD, CMD_SUB: begin
              if (alu_borrow) begin
                // swap so the larger magnitude comes first
                px_r   <= py_r;
                py_r   <= px_r;
                xneg_r <= yneg_r;
                yneg_r <= xneg_r;
              end else begin
                nm_r    <= alu_res[DW-1:0];
                nneg_r  <= xneg_r;
                state_r <= S_GZ;
              end
            end
            CMD_MUL: begin
              nm_r    <= px_r;
              nneg_r  <= (lneg_r ^ rneg_r) && (lnm_r != 64'd0) && (rnm_r != 64'd0);
              state_r <= S_GZ;
            end
            CMD_DIV: begin
              nm_r    <= px_r;
              nneg_r  <= (lneg_r ^ rneg_r) && (lnm_r != 64'd0);
              state_r <= S_GZ;
            end
            CMD_EQ: begin
              on_cmp_r <= (xneg_r == yneg_r) && alu_zero;
              state_r  <= S_PUT;
            end
            CMD_LT: begin
              if (xneg_r != yneg_r)  on_cmp_r <= xneg_r;
              else if (xneg_r)       on_cmp_r <= !alu_borrow && !alu_zero;
              else                   on_cmp_r <= alu_borrow;
              state_r <= S_PUT;
            end
            default: begin
              state_r <= S_PUT;
            end
          endcase
        end

        S_RB: begin
          if (!go_r) begin
            go_r <= 1'b1;
          end else if (div_done) begin
            go_r <= 1'b0;
            if (div_rem != '0) begin
              on_st_r <= ST_INEX;
              state_r <= S_PUT;
            end else begin
              nm_r    <= div_quo;
              nneg_r  <= lneg_r;
              dd_r    <= {{(DW-63){1'b0}}, nd_r};
              state_r <= S_FIN;
            end
          end
        end

        S_GZ: begin
          if (nm_r == '0) begin
            ga_r    <= dd_r;
            state_r <= S_DN;
          end else begin
            ga_r    <= nm_r;
            gb_r    <= dd_r;
            gk_r    <= '0;
            state_r <= S_G2;
          end
        end

        S_G2: begin
          // strip common factors of two
          if (!ga_r[0] && !gb_r[0]) begin
            ga_r <= ga_r >> 1;
            gb_r <= gb_r >> 1;
            gk_r <= gk_r + 7'd1;
          end else begin
            state_r <= S_GA;
          end
        end

        S_GA: begin
          if (!ga_r[0]) ga_r <= ga_r >> 1;
          else          state_r <= S_GB;
        end

        S_GB: begin
          if (!gb_r[0]) gb_r <= gb_r >> 1;
          else          state_r <= S_GS;
        end

        S_GS: begin
          if (alu_borrow) begin
            ga_r <= gb_r;
            gb_r <= ga_r;
          end else begin
            gb_r    <= alu_res[DW-1:0];
            state_r <= alu_zero ? S_GK : S_GB;
          end
        end

        S_GK: begin
          // restore the common power of two
          if (gk_r != 7'd0) begin
            ga_r <= ga_r << 1;
            gk_r <= gk_r - 7'd1;
          end else begin
            state_r <= S_DN;
          end
        end

        S_DN: begin
          if (!go_r) begin
            go_r <= 1'b1;
          end else if (div_done) begin
            go_r    <= 1'b0;
            nm_r    <= div_quo;
            state_r <= S_DD;
          end
        end

        S_DD: begin
          if (!go_r) begin
            go_r <= 1'b1;
          end else if (div_done) begin
            go_r    <= 1'b0;
            dd_r    <= div_quo;
            state_r <= S_FIN;
          end
        end

        S_FIN: begin
          on_cmp_r <= 1'b0;
          if (num_fit && den_fit) begin
            on_num_r <= nneg_r ? (~nm_r[OW-1:0] + 64'd1) : nm_r[OW-1:0];
            on_den_r <= dd_r[62:0];
            on_st_r  <= ST_OK;
          end else begin
            on_num_r <= '0;
            on_den_r <= '0;
            on_st_r  <= ST_OVF;
          end
          state_r <= S_PUT;
        end

        S_PUT: begin
          // hold until the output register is free
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            out_num_r   <= on_num_r;
            out_den_r   <= on_den_r;
            out_cmp_r   <= on_cmp_r;
            out_st_r    <= on_st_r;
            state_r     <= S_IDLE;
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall         = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_res_num      = out_num_r;
  assign out_res_den      = out_den_r;
  assign out_compare_true = out_cmp_r;
  assign out_status       = out_st_r;

endmodule

[hdl/rau_mul.sv]
// ----------------------------------------------------------------------------
// Rational arithmetic unit multiplier
// 64 x 64 unsigned multiply over four 32 x 32 partial products.
// ----------------------------------------------------------------------------
module rau_mul import rau_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [OW-1:0] a,
  input  logic [OW-1:0] b,
  output logic          done,
  output logic [DW-1:0] prod
);

  logic          busy_r;
  logic          ppv_r;
  logic          done_r;
  logic [2:0]    cnt_r;
  logic [1:0]    sh_r;
  logic [OW-1:0] pp_r;
  logic [DW-1:0] acc_r;
  logic [31:0]   ai;
  logic [31:0]   bi;
  logic [DW-1:0] pp_shift;

  assign ai = cnt_r[0] ? a[63:32] : a[31:0];
  assign bi = cnt_r[1] ? b[63:32] : b[31:0];
  assign pp_shift = {{(DW-OW){1'b0}}, pp_r} << {sh_r, 5'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ppv_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && !start && (cnt_r == 3'd4);
      if (start) begin
        busy_r <= 1'b1;
        ppv_r  <= 1'b0;
        cnt_r  <= '0;
        acc_r  <= '0;
      end else if (busy_r) begin
        // form one partial product, add the previous one
        if (cnt_r != 3'd4) begin
          pp_r  <= ai * bi;
          sh_r  <= {1'b0, cnt_r[0]} + {1'b0, cnt_r[1]};
          ppv_r <= 1'b1;
          cnt_r <= cnt_r + 3'd1;
        end else begin
          ppv_r  <= 1'b0;
          busy_r <= 1'b0;
        end
        if (ppv_r) begin
          acc_r <= acc_r + pp_shift;
        end
      end
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

[hdl/rau_div.sv]
// ----------------------------------------------------------------------------
// Rational arithmetic unit divider
// Restoring 128 / 128 unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rau_div import rau_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [DW-1:0] quo,
  output logic [DW-1:0] rem
);

  logic          busy_r;
  logic          done_r;
  logic [6:0]    cnt_r;
  logic [DW-1:0] rr_r;
  logic [DW-1:0] qq_r;
  logic [DW-1:0] dn_r;
  logic [DW:0]   rs;
  logic [DW:0]   diff;
  logic          ge;

  assign rs   = {rr_r, qq_r[DW-1]};
  assign diff = rs - {1'b0, dn_r};
  assign ge   = !diff[DW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && !start && (cnt_r == 7'd127);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rr_r   <= '0;
        qq_r   <= num;
        dn_r   <= den;
      end else if (busy_r) begin
        // shift in next dividend bit, subtract when it fits
        rr_r  <= ge ? diff[DW-1:0] : rs[DW-1:0];
        qq_r  <= {qq_r[DW-2:0], ge};
        cnt_r <= cnt_r + 7'd1;
        if (cnt_r == 7'd127) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = qq_r;
  assign rem  = rr_r;

endmodule
